>>> design/lpsg_pkg.sv
// lpsg_pkg: types, codes and thresholds shared by the lift/place stop guard
// used by lpsg_step and lift_place_stop_guard; depends on nothing
package lpsg_pkg;

	// configuration register indexes
	localparam logic CFG_UPRIGHT_REF      = 1'b0;
	localparam logic CFG_LIFT_ACCEL_LIMIT = 1'b1;

	localparam logic [14:0] LIFT_ACCEL_RESET = 15'd26000;

	// pick-up detector thresholds
	localparam logic [17:0]        STILL_SUM_LIMIT  = 18'd30;
	localparam logic [3:0]         STILL_TICKS_NEED = 4'd10;
	localparam logic [7:0]         LIFT_TIMEOUT     = 8'd200;
	localparam logic signed [16:0] LIFT_WINDOW      = 17'sd2000;
	localparam logic [6:0]         SPIN_TIMEOUT     = 7'd100;
	localparam logic signed [16:0] SPIN_LIMIT       = 17'sd70;

	// put-down detector thresholds
	localparam logic [5:0]         PLACE_TIMEOUT    = 6'd50;
	localparam logic signed [16:0] PLACE_WINDOW     = 17'sd1000;
	localparam logic signed [15:0] PLACE_TURN_LOW   = 16'sd3;
	localparam logic signed [15:0] PLACE_TURN_HIGH  = 16'sd40;

	// mode dial borders
	localparam logic signed [15:0] DIAL_LEFT_LIMIT  = 16'sd10;
	localparam logic [16:0]        DIAL_NORMAL_LOW  = 17'd6;
	localparam logic [16:0]        DIAL_AVOID_LOW   = 17'd180;
	localparam logic [16:0]        DIAL_FOLLOW_LOW  = 17'd360;
	localparam logic [16:0]        DIAL_WRAP        = 17'd540;

	typedef enum logic [2:0] {
		LIFT_STILL = 3'b001,
		LIFT_RAISE = 3'b010,
		LIFT_SPIN  = 3'b100
	} lift_stage_t;

	typedef enum logic [1:0] {
		PLACE_LEVEL = 2'b01,
		PLACE_TURN  = 2'b10
	} place_stage_t;

	typedef enum logic [1:0] {
		MODE_NORMAL = 2'd0,
		MODE_AVOID  = 2'd1,
		MODE_FOLLOW = 2'd2
	} run_mode_t;

	typedef struct packed {
		logic signed [12:0] upright_ref;
		logic [14:0]        lift_accel_limit;
	} cfg_t;

	typedef struct packed {
		logic signed [15:0] accel_z;
		logic signed [15:0] tilt_angle;
		logic signed [15:0] left_count;
		logic signed [15:0] right_count;
		logic               stop_toggle;
	} item_t;

	typedef struct packed {
		logic      stopped;
		run_mode_t run_mode;
		logic      picked_up;
		logic      put_down;
	} result_t;

	typedef struct packed {
		logic         stop_flag;
		lift_stage_t  lift_stage;
		logic [3:0]   still_ticks;
		logic [7:0]   lift_wait_ticks;
		logic [6:0]   spin_wait_ticks;
		place_stage_t place_stage;
		logic [5:0]   place_wait_ticks;
		logic [9:0]   dial_count;
		run_mode_t    run_mode;
	} guard_state_t;

	localparam guard_state_t STATE_RESET = '{
		stop_flag:        1'b0,
		lift_stage:       LIFT_STILL,
		still_ticks:      4'd0,
		lift_wait_ticks:  8'd0,
		spin_wait_ticks:  7'd0,
		place_stage:      PLACE_LEVEL,
		place_wait_ticks: 6'd0,
		dial_count:       10'd0,
		run_mode:         MODE_NORMAL
	};

endpackage

>>> design/lpsg_step.sv
// lpsg_step: next-state and result logic for one control tick
// depends on lpsg_pkg
module lpsg_step
	import lpsg_pkg::*;
(
	input  cfg_t         cfg,
	input  guard_state_t st,
	input  item_t        item,
	output guard_state_t nxt,
	output result_t      res
);

	function automatic logic [16:0] mag17(input logic signed [15:0] v);
		logic signed [16:0] x;
		x = 17'(v);
		mag17 = x[16] ? 17'(-x) : 17'(x);
	endfunction

	logic [16:0]        abs_l;
	logic [16:0]        abs_r;
	logic [17:0]        still_sum;
	logic signed [16:0] pair_sum;
	logic signed [16:0] mid_x;
	logic signed [16:0] ang_x;
	logic signed [16:0] az_x;
	logic               lift_ok;
	logic               spin_ok;
	logic               level_ok;
	logic               turn_ok;
	logic [16:0]        dial_sum;
	logic               stop;
	logic               picked;
	logic               placed;

	always_comb begin
		abs_l     = mag17(item.left_count);
		abs_r     = mag17(item.right_count);
		still_sum = {1'b0, abs_l} + {1'b0, abs_r};
		pair_sum  = 17'(item.left_count) + 17'(item.right_count);
		mid_x     = 17'(cfg.upright_ref);
		ang_x     = 17'(item.tilt_angle);
		az_x      = 17'(item.accel_z);

		lift_ok  = (az_x > $signed({2'b00, cfg.lift_accel_limit}))
			&& (ang_x > mid_x - LIFT_WINDOW) && (ang_x < mid_x + LIFT_WINDOW);
		spin_ok  = (pair_sum > SPIN_LIMIT) || (pair_sum < -SPIN_LIMIT);
		level_ok = (ang_x > mid_x - PLACE_WINDOW) && (ang_x < mid_x + PLACE_WINDOW)
			&& (item.left_count == 16'sd0) && (item.right_count == 16'sd0);
		turn_ok  = (item.left_count > PLACE_TURN_LOW) && (item.right_count > PLACE_TURN_LOW)
			&& (item.left_count < PLACE_TURN_HIGH) && (item.right_count < PLACE_TURN_HIGH);
		dial_sum = 17'({7'd0, st.dial_count}) + abs_r;

		nxt    = st;
		stop   = st.stop_flag ^ item.stop_toggle;
		picked = 1'b0;
		placed = 1'b0;

		// pick-up detector, stages fall through on the same tick
		if (nxt.lift_stage == LIFT_STILL) begin
			if (still_sum < STILL_SUM_LIMIT) begin
				nxt.still_ticks = st.still_ticks + 4'd1;
			end else begin
				nxt.still_ticks = 4'd0;
			end
			if (nxt.still_ticks > STILL_TICKS_NEED) begin
				nxt.lift_stage  = LIFT_RAISE;
				nxt.still_ticks = 4'd0;
			end
		end
		if (nxt.lift_stage == LIFT_RAISE) begin
			nxt.lift_wait_ticks = st.lift_wait_ticks + 8'd1;
			if (nxt.lift_wait_ticks > LIFT_TIMEOUT) begin
				nxt.lift_wait_ticks = 8'd0;
				nxt.lift_stage      = LIFT_STILL;
			end
			if (lift_ok) begin
				nxt.lift_stage = LIFT_SPIN;
			end
		end
		if (nxt.lift_stage == LIFT_SPIN) begin
			nxt.spin_wait_ticks = st.spin_wait_ticks + 7'd1;
			if (nxt.spin_wait_ticks > SPIN_TIMEOUT) begin
				nxt.spin_wait_ticks = 7'd0;
				nxt.lift_stage      = LIFT_STILL;
			end
			if (spin_ok) begin
				nxt.lift_stage = LIFT_STILL;
				picked         = 1'b1;
			end
		end
		if (picked) begin
			stop = 1'b1;
		end

		// put-down detector, idle while running
		if (stop) begin
			if (nxt.place_stage == PLACE_LEVEL && level_ok) begin
				nxt.place_stage = PLACE_TURN;
			end
			if (nxt.place_stage == PLACE_TURN) begin
				nxt.place_wait_ticks = st.place_wait_ticks + 6'd1;
				if (nxt.place_wait_ticks > PLACE_TIMEOUT) begin
					nxt.place_wait_ticks = 6'd0;
					nxt.place_stage      = PLACE_LEVEL;
				end
				if (turn_ok) begin
					nxt.place_stage = PLACE_LEVEL;
					placed          = 1'b1;
				end
			end
		end
		if (placed) begin
			stop = 1'b0;
		end

		// mode dial
		if (!stop) begin
			nxt.dial_count = 10'd0;
		end
		if (stop && (item.left_count < DIAL_LEFT_LIMIT)) begin
			if (dial_sum > DIAL_NORMAL_LOW && dial_sum < DIAL_AVOID_LOW) begin
				nxt.run_mode = MODE_NORMAL;
			end
			if (dial_sum > DIAL_AVOID_LOW && dial_sum < DIAL_FOLLOW_LOW) begin
				nxt.run_mode = MODE_AVOID;
			end
			if (dial_sum > DIAL_FOLLOW_LOW && dial_sum < DIAL_WRAP) begin
				nxt.run_mode = MODE_FOLLOW;
			end
			if (dial_sum > DIAL_WRAP) begin
				nxt.dial_count = 10'd0;
			end else begin
				nxt.dial_count = dial_sum[9:0];
			end
		end

		nxt.stop_flag = stop;

		res.stopped   = stop;
		res.run_mode  = nxt.run_mode;
		res.picked_up = picked;
		res.put_down  = placed;
	end

endmodule

>>> design/lift_place_stop_guard.sv
// lift_place_stop_guard: top level of the pick-up / put-down stop guard
// depends on lpsg_pkg and lpsg_step
//
// One result per input transaction, one transaction per clock sustained while
// the output is not stalled. A transaction lands in an input register when
// accepted; the guard state and the result register are updated when it
// advances, which waits while the result register holds a stalled result. The
// combinational state update in lpsg_step sets this rate. Configuration takes
// effect on the next tick evaluated.
module lift_place_stop_guard
	import lpsg_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// [15:0] accel_z, [31:16] tilt_angle, [47:32] left_count,
	// [63:48] right_count, [64] stop_toggle, [71:65] zero
	input  logic [71:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	// [0] stopped, [2:1] run_mode, [3] picked_up, [4] put_down, [7:5] zero
	output logic [7:0]  m_tdata,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [14:0] cfg_data
);

	cfg_t         cfg_q;
	guard_state_t state_q;
	guard_state_t state_nxt;
	item_t        item_s1;
	logic         valid_s1;
	result_t      res_nxt;
	result_t      res_q;
	logic         m_valid_q;
	logic         advance;

	assign advance  = valid_s1 && (!m_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.upright_ref      <= '0;
			cfg_q.lift_accel_limit <= LIFT_ACCEL_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_UPRIGHT_REF:      cfg_q.upright_ref      <= cfg_data[12:0];
				CFG_LIFT_ACCEL_LIMIT: cfg_q.lift_accel_limit <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1.accel_z     <= s_tdata[15:0];
			item_s1.tilt_angle  <= s_tdata[31:16];
			item_s1.left_count  <= s_tdata[47:32];
			item_s1.right_count <= s_tdata[63:48];
			item_s1.stop_toggle <= s_tdata[64];
		end
	end

	lpsg_step u_step (
		.cfg  (cfg_q),
		.st   (state_q),
		.item (item_s1),
		.nxt  (state_nxt),
		.res  (res_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= STATE_RESET;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (advance) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_nxt;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {3'b000, res_q.put_down, res_q.picked_up, res_q.run_mode, res_q.stopped};

endmodule

>>> design/lpsg_checker.sv
// lpsg_checker: port-level assertions for lift_place_stop_guard
// bound to the top level below; depends on nothing
module lpsg_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       s_tready,
	input logic       m_tvalid,
	input logic       m_tready,
	input logic [7:0] m_tdata
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// an empty result register never blocks the input side
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled with empty output");

	// a pick-up without a put-down leaves the body stopped
	a_pick_stops: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[3] && !m_tdata[4] |-> m_tdata[0])
		else $error("pick-up reported but not stopped");

	// a put-down always releases the stop
	a_place_runs: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[4] |-> !m_tdata[0])
		else $error("put-down reported but still stopped");

	// only three run modes exist
	a_mode_legal: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[2:1] != 2'd3)
		else $error("illegal run mode");

endmodule

bind lift_place_stop_guard lpsg_checker u_lpsg_checker (.*);

>>> dv/lift_place_stop_guard_test.sv
// lift_place_stop_guard_test: self-checking bench for the pick-up / put-down stop guard
// drives tick transactions over the stream ports, predicts every result in place and
// compares it field by field; depends on lpsg_pkg and the lift_place_stop_guard rtl
`timescale 1ns / 100ps

module lift_place_stop_guard_test;
	import lpsg_pkg::*;

	localparam int QUIET_SUM       = 30;
	localparam int QUIET_TICKS     = 10;
	localparam int RAISE_TICKS_MAX = 200;
	localparam int RAISE_BAND      = 2000;
	localparam int SPIN_TICKS_MAX  = 100;
	localparam int SPIN_SUM        = 70;
	localparam int LAND_TICKS_MAX  = 50;
	localparam int LAND_BAND       = 1000;
	localparam int NUDGE_LO        = 3;
	localparam int NUDGE_HI        = 40;
	localparam int DIAL_LEFT_MAX   = 10;
	localparam int DIAL_FLOOR      = 6;
	localparam int DIAL_AVOID_AT   = 180;
	localparam int DIAL_FOLLOW_AT  = 360;
	localparam int DIAL_TOP        = 540;

	typedef enum {TRACK_STILL, TRACK_RAISE, TRACK_SPIN} lift_track_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [71:0] s_tdata = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [7:0]  m_tdata;
	logic        cfg_we = 1'b0;
	logic        cfg_index = CFG_UPRIGHT_REF;
	logic [14:0] cfg_data = '0;

	// guard shadow state and configuration
	bit          halted = 1'b0;
	lift_track_t lift_track = TRACK_STILL;
	int          quiet_run = 0;
	int          raise_wait = 0;
	int          spin_wait = 0;
	bit          land_armed = 1'b0;
	int          land_wait = 0;
	int          dial_sum = 0;
	run_mode_t   dial_mode = MODE_NORMAL;
	int          cfg_mid = 0;
	int          cfg_limit = 26000;

	item_t   pending_ticks[$];
	result_t expected_results[$];
	item_t   offered_tick;
	result_t want;
	int      ticks_queued = 0;
	int      bad_results = 0;
	int      send_idle_pct = 0;
	int      recv_stall_pct = 0;
	bit      hold_armed = 1'b0;
	bit      hold_done = 1'b0;
	int      hold_left = 0;

	lift_place_stop_guard dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #4 clk = ~clk;

	function automatic int absval(int v);
		return v < 0 ? -v : v;
	endfunction

	function automatic int rand_between(int lo, int hi);
		return lo + int'($urandom_range(hi - lo));
	endfunction

	function automatic result_t step_guard(item_t t);
		int      az, ang, el, er, total;
		bit      picked, placed;
		result_t r;
		az = int'($signed(t.accel_z));
		ang = int'($signed(t.tilt_angle));
		el = int'($signed(t.left_count));
		er = int'($signed(t.right_count));
		picked = 1'b0;
		placed = 1'b0;
		if (t.stop_toggle)
			halted = !halted;

		if (lift_track == TRACK_STILL) begin
			if (absval(el) + absval(er) < QUIET_SUM)
				quiet_run++;
			else
				quiet_run = 0;
			if (quiet_run > QUIET_TICKS) begin
				lift_track = TRACK_RAISE;
				quiet_run = 0;
			end
		end
		if (lift_track == TRACK_RAISE) begin
			raise_wait++;
			if (raise_wait > RAISE_TICKS_MAX) begin
				raise_wait = 0;
				lift_track = TRACK_STILL;
			end
			if (az > cfg_limit && ang > cfg_mid - RAISE_BAND && ang < cfg_mid + RAISE_BAND)
				lift_track = TRACK_SPIN;
		end
		if (lift_track == TRACK_SPIN) begin
			spin_wait++;
			if (spin_wait > SPIN_TICKS_MAX) begin
				spin_wait = 0;
				lift_track = TRACK_STILL;
			end
			if (absval(el + er) > SPIN_SUM) begin
				lift_track = TRACK_STILL;
				picked = 1'b1;
			end
		end
		if (picked)
			halted = 1'b1;

		if (halted) begin
			if (!land_armed && ang > cfg_mid - LAND_BAND && ang < cfg_mid + LAND_BAND &&
					el == 0 && er == 0)
				land_armed = 1'b1;
			if (land_armed) begin
				land_wait++;
				if (land_wait > LAND_TICKS_MAX) begin
					land_wait = 0;
					land_armed = 1'b0;
				end
				if (el > NUDGE_LO && er > NUDGE_LO && el < NUDGE_HI && er < NUDGE_HI) begin
					land_armed = 1'b0;
					placed = 1'b1;
				end
			end
		end
		if (placed)
			halted = 1'b0;

		if (!halted)
			dial_sum = 0;
		if (halted && el < DIAL_LEFT_MAX) begin
			total = dial_sum + absval(er);
			if (total > DIAL_FLOOR && total < DIAL_AVOID_AT)
				dial_mode = MODE_NORMAL;
			if (total > DIAL_AVOID_AT && total < DIAL_FOLLOW_AT)
				dial_mode = MODE_AVOID;
			if (total > DIAL_FOLLOW_AT && total < DIAL_TOP)
				dial_mode = MODE_FOLLOW;
			if (total > DIAL_TOP)
				total = 0;
			dial_sum = total;
		end

		r.stopped = halted;
		r.run_mode = dial_mode;
		r.picked_up = picked;
		r.put_down = placed;
		return r;
	endfunction

	// sender
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
		end else begin
			if (s_tvalid && s_tready)
				expected_results.push_back(step_guard(offered_tick));
			if (!s_tvalid || s_tready) begin
				if (pending_ticks.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
					offered_tick = pending_ticks.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= {7'd0, offered_tick.stop_toggle, offered_tick.right_count,
						offered_tick.left_count, offered_tick.tilt_angle, offered_tick.accel_z};
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// receiver, with one long hold-off when armed
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			hold_left = 0;
		end else begin
			if (hold_armed && !hold_done) begin
				hold_left = 120;
				hold_done = 1'b1;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	// result checker
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_results.size() == 0) begin
				bad_results++;
				if (bad_results <= 10)
					$display("%t unexpected result transaction %h", $realtime, m_tdata);
			end else begin
				want = expected_results.pop_front();
				if (m_tdata[0] !== want.stopped || m_tdata[2:1] !== want.run_mode ||
						m_tdata[3] !== want.picked_up || m_tdata[4] !== want.put_down) begin
					bad_results++;
					if (bad_results <= 10)
						$display("%t mismatch stopped %b/%b mode %0d/%0d picked %b/%b placed %b/%b",
							$realtime, want.stopped, m_tdata[0], want.run_mode, m_tdata[2:1],
							want.picked_up, m_tdata[3], want.put_down, m_tdata[4]);
				end
			end
		end
	end

	task automatic push_tick(int az, int ang, int el, int er, bit tog);
		item_t t;
		t.accel_z = az[15:0];
		t.tilt_angle = ang[15:0];
		t.left_count = el[15:0];
		t.right_count = er[15:0];
		t.stop_toggle = tog;
		pending_ticks.push_back(t);
		ticks_queued++;
	endtask

	function automatic bit rare_toggle();
		return $urandom_range(99) < 4;
	endfunction

	task automatic lift_run();
		int spin, el;
		repeat (rand_between(8, 13))
			push_tick(rand_between(-32768, 32767), rand_between(-18000, 18000),
				rand_between(-15, 15), rand_between(-15, 15), rare_toggle());
		repeat (rand_between(0, 4))
			push_tick(rand_between(-32768, 32767), rand_between(-18000, 18000),
				rand_between(-14, 14), rand_between(-14, 14), rare_toggle());
		push_tick(cfg_limit < 32767 ? rand_between(cfg_limit + 1, 32767) :
			rand_between(-32768, 32767), cfg_mid + rand_between(-RAISE_BAND, RAISE_BAND),
			rand_between(-14, 14), rand_between(-14, 14), rare_toggle());
		repeat (rand_between(0, 3))
			push_tick(rand_between(-32768, 32767), rand_between(-18000, 18000),
				rand_between(-35, 35), rand_between(-35, 35), rare_toggle());
		spin = rand_between(SPIN_SUM, 3000);
		if ($urandom_range(1))
			spin = -spin;
		el = rand_between(-1000, 1000);
		push_tick(rand_between(-32768, 32767), rand_between(-18000, 18000), el, spin - el,
			rare_toggle());
	endtask

	task automatic place_run();
		push_tick(rand_between(-32768, 32767), cfg_mid + rand_between(-LAND_BAND, LAND_BAND),
			$urandom_range(9) == 0, 0, rare_toggle());
		repeat (rand_between(0, 5))
			push_tick(rand_between(-32768, 32767), rand_between(-18000, 18000),
				rand_between(-3, 3), rand_between(-3, 3), rare_toggle());
		push_tick(rand_between(-32768, 32767), rand_between(-18000, 18000),
			rand_between(NUDGE_LO, NUDGE_HI), rand_between(NUDGE_LO, NUDGE_HI), rare_toggle());
	endtask

	task automatic dial_run();
		repeat (rand_between(2, 8))
			push_tick(rand_between(-32768, 32767), rand_between(-18000, 18000),
				rand_between(-60, DIAL_LEFT_MAX), rand_between(-260, 260), rare_toggle());
	endtask

	task automatic fill_random(int count);
		int start, pick;
		start = ticks_queued;
		while (ticks_queued - start < count) begin
			pick = $urandom_range(99);
			if (pick < 30)
				lift_run();
			else if (pick < 50)
				place_run();
			else if (pick < 70)
				dial_run();
			else if (pick < 80)
				push_tick(0, cfg_mid, 0, 0, 1'b1);
			else
				push_tick(rand_between(-32768, 32767), rand_between(-18000, 18000),
					rand_between(-32768, 32767), rand_between(-32768, 32767),
					$urandom_range(3) == 0);
		end
	endtask

	task automatic drain();
		@(negedge clk);
		while (pending_ticks.size() > 0 || s_tvalid || expected_results.size() > 0)
			@(negedge clk);
		repeat (4)
			@(negedge clk);
	endtask

	task automatic set_config(int mid, int limit);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= CFG_UPRIGHT_REF;
		cfg_data <= 15'(mid);
		@(posedge clk);
		cfg_index <= CFG_LIFT_ACCEL_LIMIT;
		cfg_data <= 15'(limit);
		@(posedge clk);
		cfg_we <= 1'b0;
		cfg_mid = mid;
		cfg_limit = limit;
	endtask

	initial begin
		repeat (11)
			@(posedge clk);
		arst_n <= 1'b1;
		repeat (2)
			@(posedge clk);

		// default setting, directed ticks, no idling
		set_config(0, 26000);
		push_tick(32767, 18000, 32767, 32767, 1'b0);
		push_tick(-32768, -18000, -32768, -32768, 1'b1);
		push_tick(0, 0, 100, -100, 1'b1);
		push_tick(0, 0, 0, 0, 1'b1);
		// still run that falls straight through the raise stage
		repeat (11)
			push_tick(30000, 0, 0, 0, 1'b0);
		// spin and nudge on one tick: pick-up and put-down together
		push_tick(0, 0, 39, 39, 1'b0);
		// dial borders while stopped
		push_tick(0, 0, 0, 180, 1'b1);
		push_tick(0, 0, 0, -180, 1'b0);
		push_tick(0, 0, 0, 180, 1'b0);
		push_tick(0, 0, 0, 1, 1'b0);
		push_tick(0, 0, 0, 6, 1'b0);
		push_tick(0, 0, 0, 200, 1'b0);
		push_tick(0, 0, 0, 200, 1'b0);
		push_tick(0, 0, 5, 5, 1'b1);
		push_tick(0, 0, 0, 0, 1'b0);
		fill_random(180);
		drain();

		send_idle_pct = 61;
		set_config(-4000, 0);
		fill_random(190);
		drain();

		send_idle_pct = 0;
		recv_stall_pct = 61;
		set_config(4000, 32767);
		fill_random(190);
		hold_armed = 1'b1;
		drain();

		send_idle_pct = 31;
		recv_stall_pct = 31;
		set_config(rand_between(-4000, 4000), rand_between(10000, 30000));
		fill_random(95);
		drain();
		fill_random(95);
		drain();

		send_idle_pct = 0;
		recv_stall_pct = 0;
		set_config(1500, 20000);
		fill_random(200);
		drain();

		repeat (8)
			@(posedge clk);
		if (bad_results == 0 && expected_results.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		#4000000;
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule

>>> files.f
design/lpsg_pkg.sv
design/lpsg_step.sv
design/lift_place_stop_guard.sv
design/lpsg_checker.sv
dv/lift_place_stop_guard_test.sv
